/* sv/dary_heap_priority_queue_defines.svh */
// Assertion macros for the d-ary heap priority queue.
// Included by the files that carry concurrent assertions; no other dependencies.
`ifndef DARY_HEAP_PRIORITY_QUEUE_DEFINES_SVH
`define DARY_HEAP_PRIORITY_QUEUE_DEFINES_SVH

`ifndef ASSERT_OFF
// When a holds at an edge, b must hold at the same edge.
`define ASSERT_IMPL(lbl, clk, rst_n, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("%m: implication check failed");
// When a holds at an edge, b must hold at the next edge.
`define ASSERT_NEXT(lbl, clk, rst_n, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("%m: next-cycle check failed");
`else
`define ASSERT_IMPL(lbl, clk, rst_n, a, b)
`define ASSERT_NEXT(lbl, clk, rst_n, a, b)
`endif

`endif

/* sv/dhpq_pkg.sv */
// Shared types and constants for the d-ary heap priority queue.
// No dependencies; used by the interfaces and every module of the block.
package dhpq_pkg;

  // Fixed payload widths of the request and response channels.
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;
  localparam int OCC_W    = 9;

  // Request type codes.
  localparam logic REQ_PUSH = 1'b0;
  localparam logic REQ_POP  = 1'b1;

  // Response status codes.
  localparam logic [STATUS_W-1:0] STATUS_DONE  = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

  // Depth of the command queue between the front and the engine.
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // What the engine has to do with a classified request.
  typedef enum logic [1:0] {
    CMD_PUSH,
    CMD_POP,
    CMD_PASS
  } cmd_kind_e;

  // A classified request; status and occupancy are already known.
  typedef struct packed {
    cmd_kind_e             kind;
    logic [VALUE_W-1:0]    value;
    logic [STATUS_W-1:0]   status;
    logic [OCC_W-1:0]      occupancy;
  } cmd_t;

endpackage

/* sv/dhpq_req_if.sv */
// Request channel of the heap priority queue: valid, ready and payload.
// Depends on dhpq_pkg for the payload widths.
interface dhpq_req_if;
  import dhpq_pkg::*;

  logic               valid;
  logic               ready;
  logic               req_type;
  logic [VALUE_W-1:0] push_value;

  modport source (output valid, output req_type, output push_value, input ready);
  modport sink   (input valid, input req_type, input push_value, output ready);

endinterface

/* sv/dhpq_rsp_if.sv */
// Response channel of the heap priority queue: valid, ready and payload.
// Depends on dhpq_pkg for the payload widths.
interface dhpq_rsp_if;
  import dhpq_pkg::*;

  logic                valid;
  logic                ready;
  logic [VALUE_W-1:0]  pop_value;
  logic [STATUS_W-1:0] status;
  logic [OCC_W-1:0]    occupancy;

  modport source (output valid, output pop_value, output status, output occupancy,
                  input ready);
  modport sink   (input valid, input pop_value, input status, input occupancy,
                  output ready);

endinterface

/* sv/dary_heap_priority_queue.sv */
// The engine works on one request at a time, with at most one key memory read per cycle;
// the front keeps accepting beats until two classified requests wait in the queue,
// also while the engine is busy and a response waits to be taken.
// Reset clears the key count, the queue, the response register and the order bit;
// the key store itself is not cleared and there is no clearing pass.
`include "dary_heap_priority_queue_defines.svh"

module dary_heap_priority_queue #(
  parameter int ARITY     = 2,
  parameter int DEPTH     = 256,
  parameter int KEY_WIDTH = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_wdata_i,
  dhpq_req_if.sink   req,
  dhpq_rsp_if.source rsp
);
  import dhpq_pkg::*;

  logic order_q;
  logic front_valid, front_ready;
  cmd_t front_cmd;
  logic eng_valid, eng_ready;
  cmd_t eng_cmd;

  // Order select register: 0 serves the largest key first, 1 the smallest.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      order_q <= 1'b0;
    end else if (cfg_we_i) begin
      order_q <= cfg_wdata_i;
    end
  end

  // Front: accept and classify request beats.
  dhpq_front #(
    .DEPTH(DEPTH)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req        (req),
    .cmd_valid_o(front_valid),
    .cmd_ready_i(front_ready),
    .cmd_o      (front_cmd)
  );

  // Queue that decouples the front from the engine.
  dhpq_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (front_valid),
    .in_ready_o (front_ready),
    .in_cmd_i   (front_cmd),
    .out_valid_o(eng_valid),
    .out_ready_i(eng_ready),
    .out_cmd_o  (eng_cmd)
  );

  // Engine: heap maintenance and the response register.
  dhpq_engine #(
    .ARITY    (ARITY),
    .DEPTH    (DEPTH),
    .KEY_WIDTH(KEY_WIDTH)
  ) u_engine (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .order_i    (order_q),
    .cmd_valid_i(eng_valid),
    .cmd_ready_o(eng_ready),
    .cmd_i      (eng_cmd),
    .rsp        (rsp)
  );

  // Taking a command leaves the engine busy and not ready for another command.
  `ASSERT_NEXT(a_engine_busy_after_take, clk_i, rst_ni, eng_valid && eng_ready, !eng_ready)
  // A failed request never returns a key.
  `ASSERT_IMPL(a_fail_no_value, clk_i, rst_ni, rsp.valid && rsp.status != STATUS_DONE, rsp.pop_value == '0)
  // A pop on an empty heap reports an empty heap.
  `ASSERT_IMPL(a_empty_occ, clk_i, rst_ni, rsp.valid && rsp.status == STATUS_EMPTY, rsp.occupancy == '0)
  // A dropped push reports a full heap.
  `ASSERT_IMPL(a_full_occ, clk_i, rst_ni, rsp.valid && rsp.status == STATUS_FULL, rsp.occupancy == OCC_W'(DEPTH))

endmodule

/* sv/dhpq_fifo.sv */
// Short command queue between the request front and the heap engine.
// Depends on dhpq_pkg for the command type and queue depth.
module dhpq_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  dhpq_pkg::cmd_t in_cmd_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output dhpq_pkg::cmd_t out_cmd_o
);
  import dhpq_pkg::*;

  cmd_t              entry_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;
  logic              push, pop;

  assign in_ready_o  = (cnt_q != QCNT_W'(QUEUE_DEPTH));
  assign out_valid_o = (cnt_q != '0);
  assign out_cmd_o   = entry_q[rd_ptr_q];
  assign push        = in_valid_i && in_ready_o;
  assign pop         = out_valid_o && out_ready_i;

  // Pointer and fill-count updates, wrapping at the queue depth.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    cnt_d = cnt_q + QCNT_W'(push) - QCNT_W'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Entry storage holds payload only and needs no reset.
  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= in_cmd_i;
    end
  end

endmodule

/* sv/dhpq_front.sv */
// Request front: accepts beats and classifies them against a running key count.
// Depends on dhpq_pkg and the request interface.
module dhpq_front #(
  parameter int DEPTH = 256
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  dhpq_req_if.sink       req,
  output logic           cmd_valid_o,
  input  logic           cmd_ready_i,
  output dhpq_pkg::cmd_t cmd_o
);
  import dhpq_pkg::*;

  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [CNT_W-1:0] cnt_q, cnt_d;

  assign req.ready   = cmd_ready_i;
  assign cmd_valid_o = req.valid;

  // Decide full/empty up front, so status and occupancy are known at once.
  always_comb begin
    cnt_d = cnt_q;
    cmd_o.value = req.push_value;
    if (req.req_type == REQ_POP) begin
      if (cnt_q == '0) begin
        cmd_o.kind   = CMD_PASS;
        cmd_o.status = STATUS_EMPTY;
      end else begin
        cmd_o.kind   = CMD_POP;
        cmd_o.status = STATUS_DONE;
        cnt_d        = cnt_q - 1'b1;
      end
    end else begin
      if (cnt_q >= CNT_W'(DEPTH)) begin
        cmd_o.kind   = CMD_PASS;
        cmd_o.status = STATUS_FULL;
      end else begin
        cmd_o.kind   = CMD_PUSH;
        cmd_o.status = STATUS_DONE;
        cnt_d        = cnt_q + 1'b1;
      end
    end
    cmd_o.occupancy = OCC_W'(cnt_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (req.valid && req.ready) begin
      cnt_q <= cnt_d;
    end
  end

endmodule

/* sv/dhpq_engine.sv */
// Heap engine: runs sift-up and sift-down over the key store, at most one read per cycle.
// Depends on dhpq_pkg and the response interface; holds the key memory.
module dhpq_engine #(
  parameter int ARITY     = 2,
  parameter int DEPTH     = 256,
  parameter int KEY_WIDTH = 32
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           order_i,
  input  logic           cmd_valid_i,
  output logic           cmd_ready_o,
  input  dhpq_pkg::cmd_t cmd_i,
  dhpq_rsp_if.source     rsp
);
  import dhpq_pkg::*;

  localparam int IDX_W   = $clog2(DEPTH);
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int CHILD_W = $clog2(DEPTH * ARITY + ARITY + 1);
  localparam int K_W     = $clog2(ARITY + 2);

  // Scaled reciprocal of the arity; exact for every slot index of the store.
  localparam int PAR_SH    = IDX_W + $clog2(ARITY);
  localparam int PAR_PW    = IDX_W + PAR_SH + 1;
  localparam int PAR_RECIP = ((1 << PAR_SH) + ARITY - 1) / ARITY;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UP_CMP,
    ST_UP_PLACE,
    ST_DN_ROOT,
    ST_DN_LAST,
    ST_DN_READ,
    ST_DN_CMP,
    ST_FINISH
  } state_e;

  // Key memory: one write and one registered read per cycle.
  logic [KEY_WIDTH-1:0] mem_q [DEPTH];
  logic [KEY_WIDTH-1:0] rdata_q;
  logic                 rd_en, wr_en;
  logic [IDX_W-1:0]     rd_addr, wr_addr;
  logic [KEY_WIDTH-1:0] wr_data;

  state_e               state_q, state_d;
  cmd_t                 cur_q, cur_d;
  logic [CNT_W-1:0]     cnt_q, cnt_d;
  logic [IDX_W-1:0]     pos_q, pos_d;
  logic [IDX_W-1:0]     par_q, par_d;
  logic [IDX_W-1:0]     child_q, child_d;
  logic [IDX_W-1:0]     best_idx_q, best_idx_d;
  logic [KEY_WIDTH-1:0] best_key_q, best_key_d;
  logic [KEY_WIDTH-1:0] key_q, key_d;
  logic [KEY_WIDTH-1:0] popped_q, popped_d;
  logic [K_W-1:0]       k_q, k_d;
  logic                 out_valid_q, out_valid_d;
  logic [VALUE_W-1:0]   out_pop_q, out_pop_d;
  logic [STATUS_W-1:0]  out_status_q, out_status_d;
  logic [OCC_W-1:0]     out_occ_q, out_occ_d;
  logic [CHILD_W-1:0]   child_w;

  // True when key a has to sit below key b under the selected order.
  function automatic logic ranks_below(input logic [KEY_WIDTH-1:0] a,
                                       input logic [KEY_WIDTH-1:0] b,
                                       input logic                 min_first);
    ranks_below = min_first ? (a > b) : (a < b);
  endfunction

  // Parent slot of a nonzero slot, taken by multiplying with the scaled reciprocal.
  function automatic logic [IDX_W-1:0] parent_of(input logic [IDX_W-1:0] x);
    logic [IDX_W-1:0]  xm;
    logic [PAR_PW-1:0] prod;
    xm        = x - 1'b1;
    prod      = PAR_PW'(xm) * PAR_PW'(PAR_RECIP);
    parent_of = IDX_W'(prod >> PAR_SH);
  endfunction

  assign cmd_ready_o   = (state_q == ST_IDLE);
  assign child_w       = CHILD_W'(pos_q) * CHILD_W'(ARITY) + CHILD_W'(k_q);
  assign rsp.valid     = out_valid_q;
  assign rsp.pop_value = out_pop_q;
  assign rsp.status    = out_status_q;
  assign rsp.occupancy = out_occ_q;

  // Sequencer: the moving key stays in a register and the hole walks the tree.
  always_comb begin
    state_d      = state_q;
    cur_d        = cur_q;
    cnt_d        = cnt_q;
    pos_d        = pos_q;
    par_d        = par_q;
    child_d      = child_q;
    best_idx_d   = best_idx_q;
    best_key_d   = best_key_q;
    key_d        = key_q;
    popped_d     = popped_q;
    k_d          = k_q;
    out_valid_d  = out_valid_q && !rsp.ready;
    out_pop_d    = out_pop_q;
    out_status_d = out_status_q;
    out_occ_d    = out_occ_q;
    rd_en        = 1'b0;
    rd_addr      = '0;
    wr_en        = 1'b0;
    wr_addr      = '0;
    wr_data      = key_q;

    unique case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i) begin
          cur_d = cmd_i;
          case (cmd_i.kind)
            CMD_PUSH: begin
              key_d = KEY_WIDTH'(cmd_i.value);
              pos_d = IDX_W'(cnt_q);
              cnt_d = cnt_q + 1'b1;
              if (cnt_q == '0) begin
                wr_en   = 1'b1;
                wr_addr = '0;
                wr_data = KEY_WIDTH'(cmd_i.value);
                state_d = ST_FINISH;
              end else begin
                par_d   = parent_of(IDX_W'(cnt_q));
                rd_en   = 1'b1;
                rd_addr = parent_of(IDX_W'(cnt_q));
                state_d = ST_UP_CMP;
              end
            end
            CMD_POP: begin
              cnt_d   = cnt_q - 1'b1;
              rd_en   = 1'b1;
              rd_addr = '0;
              state_d = ST_DN_ROOT;
            end
            default: begin
              state_d = ST_FINISH;
            end
          endcase
        end
      end

      // Parent data is in rdata_q; move it down if it ranks below the key.
      ST_UP_CMP: begin
        if (ranks_below(rdata_q, key_q, order_i)) begin
          wr_en   = 1'b1;
          wr_addr = pos_q;
          wr_data = rdata_q;
          pos_d   = par_q;
          if (par_q == '0) begin
            state_d = ST_UP_PLACE;
          end else begin
            par_d   = parent_of(par_q);
            rd_en   = 1'b1;
            rd_addr = parent_of(par_q);
          end
        end else begin
          wr_en   = 1'b1;
          wr_addr = pos_q;
          state_d = ST_FINISH;
        end
      end

      ST_UP_PLACE: begin
        wr_en   = 1'b1;
        wr_addr = pos_q;
        state_d = ST_FINISH;
      end

      // Root is in rdata_q; fetch the last key unless the heap is now empty.
      ST_DN_ROOT: begin
        popped_d = rdata_q;
        if (cnt_q == '0) begin
          state_d = ST_FINISH;
        end else begin
          rd_en   = 1'b1;
          rd_addr = IDX_W'(cnt_q);
          state_d = ST_DN_LAST;
        end
      end

      ST_DN_LAST: begin
        key_d      = rdata_q;
        pos_d      = '0;
        best_idx_d = '0;
        best_key_d = rdata_q;
        k_d        = K_W'(1);
        state_d    = ST_DN_READ;
      end

      // Fetch the next child, or act on the best child once the scan is over.
      ST_DN_READ: begin
        if (k_q > K_W'(ARITY) || child_w >= CHILD_W'(cnt_q)) begin
          if (best_idx_q == pos_q) begin
            wr_en   = 1'b1;
            wr_addr = pos_q;
            state_d = ST_FINISH;
          end else begin
            wr_en      = 1'b1;
            wr_addr    = pos_q;
            wr_data    = best_key_q;
            pos_d      = best_idx_q;
            best_key_d = key_q;
            k_d        = K_W'(1);
          end
        end else begin
          child_d = IDX_W'(child_w);
          rd_en   = 1'b1;
          rd_addr = IDX_W'(child_w);
          state_d = ST_DN_CMP;
        end
      end

      ST_DN_CMP: begin
        if (ranks_below(best_key_q, rdata_q, order_i)) begin
          best_idx_d = child_q;
          best_key_d = rdata_q;
        end
        k_d     = k_q + 1'b1;
        state_d = ST_DN_READ;
      end

      // Load the output register as soon as it is free.
      ST_FINISH: begin
        if (!out_valid_q || rsp.ready) begin
          out_valid_d  = 1'b1;
          out_pop_d    = (cur_q.kind == CMD_POP) ? VALUE_W'(popped_q) : '0;
          out_status_d = cur_q.status;
          out_occ_d    = cur_q.occupancy;
          state_d      = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      cnt_q        <= '0;
      out_valid_q  <= 1'b0;
      cur_q        <= '0;
      pos_q        <= '0;
      par_q        <= '0;
      child_q      <= '0;
      best_idx_q   <= '0;
      best_key_q   <= '0;
      key_q        <= '0;
      popped_q     <= '0;
      k_q          <= '0;
      out_pop_q    <= '0;
      out_status_q <= '0;
      out_occ_q    <= '0;
    end else begin
      state_q      <= state_d;
      cnt_q        <= cnt_d;
      out_valid_q  <= out_valid_d;
      cur_q        <= cur_d;
      pos_q        <= pos_d;
      par_q        <= par_d;
      child_q      <= child_d;
      best_idx_q   <= best_idx_d;
      best_key_q   <= best_key_d;
      key_q        <= key_d;
      popped_q     <= popped_d;
      k_q          <= k_d;
      out_pop_q    <= out_pop_d;
      out_status_q <= out_status_d;
      out_occ_q    <= out_occ_d;
    end
  end

  // Key memory write port.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
  end

  // Key memory read port with registered data.
  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rdata_q <= mem_q[rd_addr];
    end
  end

endmodule

/* sim/dary_heap_priority_queue_tb.sv */
`timescale 1ns / 100ps
// Self-checking testbench for the d-ary heap priority queue: directed, fill and random tests.
// Depends on dhpq_pkg, the dhpq_req_if and dhpq_rsp_if interfaces and the block's top level.
module dary_heap_priority_queue_tb;
  import dhpq_pkg::*;

  localparam int ARITY       = 2;
  localparam int DEPTH       = 256;
  localparam int KEY_WIDTH   = 32;
  localparam int CYCLE_LIMIT = 1_000_000;
  // Settling time after the last reply, with margin over the longest pop.
  localparam int SETTLE_CYCLES = 64;

  // Values of the order register.
  localparam logic ORDER_MAX_FIRST = 1'b0;
  localparam logic ORDER_MIN_FIRST = 1'b1;

  // How random push keys are drawn.
  typedef enum logic [1:0] {
    MIX_FULL,
    MIX_NARROW,
    MIX_EDGE
  } key_mix_e;

  typedef struct packed {
    logic [VALUE_W-1:0]  pop_value;
    logic [STATUS_W-1:0] status;
    logic [OCC_W-1:0]    occupancy;
  } reply_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic cfg_we_i;
  logic cfg_wdata_i;

  dhpq_req_if req_if ();
  dhpq_rsp_if rsp_if ();

  dary_heap_priority_queue #(
    .ARITY     (ARITY),
    .DEPTH     (DEPTH),
    .KEY_WIDTH (KEY_WIDTH)
  ) DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req         (req_if),
    .rsp         (rsp_if)
  );

  // Shadow heap kept by the testbench.
  logic [KEY_WIDTH-1:0] heap_keys [DEPTH];
  int unsigned          heap_count;
  logic                 min_first;

  reply_t      owed_replies [$];
  int unsigned src_idle_pct;
  int unsigned snk_idle_pct;
  int unsigned error_count = 0;
  int unsigned cycle_count = 0;

  always #5 clk_i = ~clk_i;

  // True when key a has to sit below key b in the current order.
  function automatic bit sits_below(logic [KEY_WIDTH-1:0] a, logic [KEY_WIDTH-1:0] b);
    return (min_first == ORDER_MIN_FIRST) ? (a > b) : (a < b);
  endfunction

  function automatic void swap_keys(int unsigned x, int unsigned y);
    logic [KEY_WIDTH-1:0] t;
    t            = heap_keys[x];
    heap_keys[x] = heap_keys[y];
    heap_keys[y] = t;
  endfunction

  // Applies one request to the shadow heap and returns the reply it owes.
  function automatic reply_t heap_request(logic rtype, logic [VALUE_W-1:0] key);
    reply_t      r;
    int unsigned pos;
    int unsigned up;
    int unsigned best;
    int unsigned c;
    bit          done;
    r    = '0;
    done = 1'b0;
    if (rtype == REQ_PUSH) begin
      if (heap_count >= DEPTH) begin
        r.status = STATUS_FULL;
      end else begin
        pos            = heap_count;
        heap_keys[pos] = key;
        while (pos != 0 && !done) begin
          up = (pos - 1) / ARITY;
          if (sits_below(heap_keys[up], heap_keys[pos])) begin
            swap_keys(up, pos);
            pos = up;
          end else begin
            done = 1'b1;
          end
        end
        heap_count++;
      end
    end else begin
      if (heap_count == 0) begin
        r.status = STATUS_EMPTY;
      end else begin
        r.pop_value  = heap_keys[0];
        heap_count--;
        heap_keys[0] = heap_keys[heap_count];
        pos          = 0;
        while (!done) begin
          best = pos;
          for (int k = 1; k <= ARITY; k++) begin
            c = pos * ARITY + k;
            if (c < heap_count && sits_below(heap_keys[best], heap_keys[c])) best = c;
          end
          if (best == pos) begin
            done = 1'b1;
          end else begin
            swap_keys(pos, best);
            pos = best;
          end
        end
      end
    end
    r.occupancy = OCC_W'(heap_count);
    return r;
  endfunction

  function automatic logic [VALUE_W-1:0] draw_key(key_mix_e mix);
    logic [VALUE_W-1:0] k;
    case (mix)
      MIX_NARROW: k = VALUE_W'($urandom_range(15));
      MIX_EDGE: begin
        case ($urandom_range(3))
          0:       k = '0;
          1:       k = '1;
          2:       k = {1'b1, {(VALUE_W-1){1'b0}}};
          default: k = {1'b0, {(VALUE_W-1){1'b1}}};
        endcase
      end
      default: k = $urandom();
    endcase
    return k;
  endfunction

  // Sends one request beat, with random idle cycles ahead of it, and books its reply.
  task automatic send_req(logic rtype, logic [VALUE_W-1:0] key);
    if ($urandom_range(99) < src_idle_pct) begin
      req_if.valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < src_idle_pct);
    end
    req_if.valid      <= 1'b1;
    req_if.req_type   <= rtype;
    req_if.push_value <= key;
    do @(posedge clk_i); while (!req_if.ready);
    owed_replies.push_back(heap_request(rtype, key));
  endtask

  task automatic send_push(logic [VALUE_W-1:0] key);
    send_req(REQ_PUSH, key);
  endtask

  // The key field of a pop is ignored, so it carries noise.
  task automatic send_pop();
    send_req(REQ_POP, $urandom());
  endtask

  // Waits until every reply has come back and the engine has gone quiet.
  task automatic wait_idle();
    req_if.valid <= 1'b0;
    while (owed_replies.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_order(logic order);
    wait_idle();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= order;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    min_first    = order;
  endtask

  // Extreme keys, ties, empty pops and an order change with keys held.
  task automatic test_directed();
    write_order(ORDER_MAX_FIRST);
    send_pop();
    send_push('0);
    send_push('1);
    send_push({1'b1, {(VALUE_W-1){1'b0}}});
    send_push(VALUE_W'(5));
    send_push(VALUE_W'(5));
    send_pop();
    send_pop();
    // Remaining keys are not reordered; later sifts use the new order.
    write_order(ORDER_MIN_FIRST);
    repeat (4) send_pop();
    send_push('1);
    send_push('0);
    send_push(VALUE_W'(5));
    send_push(VALUE_W'(5));
    send_push({1'b0, {(VALUE_W-1){1'b1}}});
    repeat (5) send_pop();
  endtask

  // Fills the heap, pushes into the full heap, then drains it to empty.
  task automatic test_fill_and_drain(logic order);
    write_order(order);
    repeat (DEPTH) send_push(draw_key(key_mix_e'($urandom_range(2))));
    repeat (2) send_push($urandom());
    repeat (DEPTH + 1) send_pop();
  endtask

  // Random runs of pushes and pops; the push share moves so occupancy sweeps up and down.
  task automatic test_random(int unsigned n_items);
    int unsigned sent;
    int unsigned push_pct;
    key_mix_e    mix;
    sent = 0;
    while (sent < n_items) begin
      case ($urandom_range(2))
        0:       push_pct = 85;
        1:       push_pct = 50;
        default: push_pct = 15;
      endcase
      mix = key_mix_e'($urandom_range(2));
      if ($urandom_range(3) == 0) write_order(logic'($urandom_range(1)));
      for (int i = 0; i < 40 && sent < n_items; i++) begin
        if ($urandom_range(99) < push_pct) send_push(draw_key(mix));
        else send_pop();
        sent++;
      end
    end
  endtask

  // Compares each response beat with the oldest owed reply; drives the random ready.
  always @(posedge clk_i) begin : reply_check
    reply_t want;
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      if (owed_replies.size() == 0) begin
        $error("response beat with no request outstanding");
        error_count++;
      end else begin
        want = owed_replies.pop_front();
        if (rsp_if.pop_value !== want.pop_value) begin
          $error("pop_value: expected %h, got %h", want.pop_value, rsp_if.pop_value);
          error_count++;
        end
        if (rsp_if.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, rsp_if.status);
          error_count++;
        end
        if (rsp_if.occupancy !== want.occupancy) begin
          $error("occupancy: expected %0d, got %0d", want.occupancy, rsp_if.occupancy);
          error_count++;
        end
      end
    end
    rsp_if.ready <= rst_ni && ($urandom_range(99) >= snk_idle_pct);
  end

  // Guard against a hung block.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    rst_ni            <= 1'b0;
    cfg_we_i          <= 1'b0;
    cfg_wdata_i       <= ORDER_MAX_FIRST;
    req_if.valid      <= 1'b0;
    req_if.req_type   <= REQ_PUSH;
    req_if.push_value <= '0;
    heap_count         = 0;
    min_first          = ORDER_MAX_FIRST;
    src_idle_pct       = 0;
    snk_idle_pct       = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    src_idle_pct = 15;
    snk_idle_pct = 65;
    test_directed();
    test_fill_and_drain(ORDER_MAX_FIRST);

    src_idle_pct = 65;
    snk_idle_pct = 15;
    test_random(230);

    src_idle_pct = 0;
    snk_idle_pct = 0;
    test_random(230);

    // Let the last replies drain before judging the run.
    req_if.valid <= 1'b0;
    while (owed_replies.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
